// File: design/slcl_pkg.sv
// Shared constants, state encodings and helpers for the set-associative LRU lookup.
// No dependencies; every other design file refers to it by scoped names.

package slcl_pkg;

   localparam int DEF_WAYS        = 2;
   localparam int DEF_SETS        = 2048;
   localparam int DEF_OFFSET_BITS = 12;

   localparam int ADDR_W      = 31;
   localparam int STAMP_W     = 32;
   localparam int COUNT_W     = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK,
      BK_SCAN,
      BK_WRITE
   } back_state_type;

   // Saturating increment for the access clock and the totals.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
      return r;
   endfunction

endpackage

// File: design/slcl_front.sv
// Front end: splits a byte address into set index and tag and pushes them to the queue.
// Depends on slcl_pkg. Power-of-two set counts split in the accept cycle, others
// divide by a reciprocal multiply in the cycle after the accept and push once the queue has room.

module slcl_front #(
   parameter int SETS        = slcl_pkg::DEF_SETS,
   parameter int OFFSET_BITS = slcl_pkg::DEF_OFFSET_BITS,
   parameter int SET_W       = 11,
   parameter int TAG_W       = 9
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [slcl_pkg::ADDR_W-1:0] address,
   input  logic                       q_full,
   output logic                       push,
   output logic [SET_W-1:0]           push_set,
   output logic [TAG_W-1:0]           push_tag,
   output logic                       ready
);

   localparam int BLOCK_W = slcl_pkg::ADDR_W - OFFSET_BITS;

   logic [BLOCK_W-1:0] block;
   assign block = address[slcl_pkg::ADDR_W-1:OFFSET_BITS];

   if ((SETS & (SETS - 1)) == 0) begin : g_shift
      // Set index is the low block bits, tag the rest.
      assign push     = accept;
      assign push_set = SET_W'(block % SETS);
      assign push_tag = TAG_W'(block / SETS);
      assign ready    = !q_full;
   end else begin : g_div
      // RECIP = ceil(2^(BLOCK_W+LOG_SETS) / SETS); the product's upper bits are the
      // exact quotient for every BLOCK_W-bit block number.
      localparam int     LOG_SETS = $clog2(SETS);
      localparam int     RECIP_W  = BLOCK_W + 1;
      localparam int     PROD_W   = BLOCK_W + RECIP_W;
      localparam longint RECIP    = ((longint'(1) << (BLOCK_W + LOG_SETS))
                                     + longint'(SETS) - longint'(1)) / longint'(SETS);

      slcl_pkg::front_state_type state_ff, state_in;
      logic [BLOCK_W-1:0] blk_ff, blk_in;
      logic [BLOCK_W-1:0] quo_ff, quo_in;
      logic [PROD_W-1:0]  prod;
      logic [BLOCK_W-1:0] rem;

      assign prod = PROD_W'(blk_ff) * PROD_W'(RECIP_W'(RECIP));
      // Remainder from the held quotient: block minus quotient times set count.
      assign rem  = blk_ff - quo_ff * BLOCK_W'(SETS);

      always_ff @(posedge clock) begin
         if (reset) begin
            state_ff <= slcl_pkg::FR_IDLE;
         end else begin
            state_ff <= state_in;
         end
         blk_ff <= blk_in;
         quo_ff <= quo_in;
      end

      always_comb begin
         state_in = state_ff;
         blk_in   = blk_ff;
         quo_in   = quo_ff;
         push     = 1'b0;
         ready    = 1'b0;
         unique case (state_ff)
            slcl_pkg::FR_IDLE: begin
               ready = 1'b1;
               if (accept) begin
                  blk_in   = block;
                  state_in = slcl_pkg::FR_DIV;
               end
            end
            slcl_pkg::FR_DIV: begin
               // Keep the upper product bits as the quotient.
               quo_in   = BLOCK_W'(prod >> (BLOCK_W + LOG_SETS));
               state_in = slcl_pkg::FR_PUSH;
            end
            slcl_pkg::FR_PUSH: begin
               if (!q_full) begin
                  push     = 1'b1;
                  state_in = slcl_pkg::FR_IDLE;
               end
            end
            default: state_in = slcl_pkg::FR_IDLE;
         endcase
      end

      assign push_set = SET_W'(rem);
      assign push_tag = TAG_W'(quo_ff);
   end

endmodule

// File: design/slcl_queue.sv
// Short FIFO between the front end and the back end.
// Depends on slcl_pkg for its default depth.

module slcl_queue #(
   parameter int DATA_W = 20,
   parameter int DEPTH  = slcl_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              full,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/slcl_back.sv
// Back end: tag/stamp memory, hit detection, LRU victim scan, totals and result beat.
// Depends on slcl_pkg. Holds one row per set with valid bits, tags and stamps of all ways.

module slcl_back #(
   parameter int WAYS  = slcl_pkg::DEF_WAYS,
   parameter int SETS  = slcl_pkg::DEF_SETS,
   parameter int SET_W = 11,
   parameter int TAG_W = 9,
   parameter int WAY_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  logic [SET_W-1:0]             q_set,
   input  logic [TAG_W-1:0]             q_tag,
   output logic                         pop,
   output logic                         clearing,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic                         rsp_way_used,
   output logic [slcl_pkg::COUNT_W-1:0] rsp_hit_total,
   output logic [slcl_pkg::COUNT_W-1:0] rsp_miss_total
);

   localparam int SW    = slcl_pkg::STAMP_W;
   localparam int CW    = slcl_pkg::COUNT_W;
   localparam int ROW_W = WAYS * (1 + TAG_W + SW);

   logic [ROW_W-1:0] mem [SETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_W-1:0] wr_row;
   logic [SET_W-1:0] wr_addr;
   logic             wr_en;

   slcl_pkg::back_state_type state_ff, state_in;

   logic [SET_W-1:0]                clr_ptr_ff, clr_ptr_in;
   logic [SET_W-1:0]                set_ff, set_in;
   logic [TAG_W-1:0]                tag_ff, tag_in;
   logic [WAYS-1:0]                 vld_ff, vld_in;
   logic [WAYS-1:0][TAG_W-1:0]      tags_ff, tags_in;
   logic [WAYS-1:0][SW-1:0]         stamps_ff, stamps_in;
   logic [WAY_W-1:0]                way_ff, way_in;
   logic [WAY_W-1:0]                idx_ff, idx_in;
   logic [SW-1:0]                   min_ff, min_in;
   logic                            hit_ff, hit_in;
   logic [SW-1:0]                   clk_ff, clk_in;
   logic [CW-1:0]                   hit_cnt_ff, hit_cnt_in;
   logic [CW-1:0]                   miss_cnt_ff, miss_cnt_in;
   logic                            strobe_ff, strobe_in;

   logic [WAYS-1:0]                 rd_vld;
   logic [WAYS-1:0][TAG_W-1:0]      rd_tags;
   logic [WAYS-1:0][SW-1:0]         rd_stamps;
   logic                            look_hit;
   logic [WAY_W-1:0]                look_way;
   logic [WAYS-1:0]                 new_vld;
   logic [WAYS-1:0][TAG_W-1:0]      new_tags;
   logic [WAYS-1:0][SW-1:0]         new_stamps;

   assign rd_vld    = rd_row_ff[ROW_W-1 -: WAYS];
   assign rd_tags   = rd_row_ff[WAYS*(TAG_W+SW)-1 -: WAYS*TAG_W];
   assign rd_stamps = rd_row_ff[WAYS*SW-1:0];

   // Lowest valid way whose tag matches.
   always_comb begin
      look_hit = 1'b0;
      look_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (rd_vld[w] && (rd_tags[w] == tag_ff)) begin
            look_hit = 1'b1;
            look_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      new_vld             = vld_ff;
      new_tags            = tags_ff;
      new_stamps          = stamps_ff;
      new_vld[way_ff]     = 1'b1;
      new_tags[way_ff]    = tag_ff;
      new_stamps[way_ff]  = clk_ff;
   end

   // Memory: one write port shared by the clearing sweep and the update.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= mem[q_set];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= slcl_pkg::BK_CLEAR;
         clr_ptr_ff  <= '0;
         clk_ff      <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ptr_ff  <= clr_ptr_in;
         clk_ff      <= clk_in;
         hit_cnt_ff  <= hit_cnt_in;
         miss_cnt_ff <= miss_cnt_in;
         strobe_ff   <= strobe_in;
      end
      set_ff    <= set_in;
      tag_ff    <= tag_in;
      vld_ff    <= vld_in;
      tags_ff   <= tags_in;
      stamps_ff <= stamps_in;
      way_ff    <= way_in;
      idx_ff    <= idx_in;
      min_ff    <= min_in;
      hit_ff    <= hit_in;
      if (state_ff == slcl_pkg::BK_WRITE) begin
         rsp_hit        <= hit_ff;
         rsp_way_used   <= way_ff[0];
         rsp_hit_total  <= hit_cnt_ff;
         rsp_miss_total <= miss_cnt_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_ptr_in  = clr_ptr_ff;
      set_in      = set_ff;
      tag_in      = tag_ff;
      vld_in      = vld_ff;
      tags_in     = tags_ff;
      stamps_in   = stamps_ff;
      way_in      = way_ff;
      idx_in      = idx_ff;
      min_in      = min_ff;
      hit_in      = hit_ff;
      clk_in      = clk_ff;
      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      strobe_in   = 1'b0;
      pop         = 1'b0;
      clearing    = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = set_ff;
      wr_row      = {new_vld, new_tags, new_stamps};
      unique case (state_ff)
         slcl_pkg::BK_CLEAR: begin
            // Invalidate one row a cycle, stamps to zero.
            clearing   = 1'b1;
            wr_en      = 1'b1;
            wr_addr    = clr_ptr_ff;
            wr_row     = '0;
            clr_ptr_in = clr_ptr_ff + SET_W'(1);
            if (clr_ptr_ff == SET_W'(SETS - 1)) begin
               state_in = slcl_pkg::BK_IDLE;
            end
         end
         slcl_pkg::BK_IDLE: begin
            // The row read of the head entry is issued at this edge.
            if (!q_empty) begin
               pop      = 1'b1;
               set_in   = q_set;
               tag_in   = q_tag;
               state_in = slcl_pkg::BK_LOOK;
            end
         end
         slcl_pkg::BK_LOOK: begin
            vld_in    = rd_vld;
            tags_in   = rd_tags;
            stamps_in = rd_stamps;
            hit_in    = look_hit;
            clk_in    = slcl_pkg::sat_inc(clk_ff);
            min_in    = rd_stamps[0];
            idx_in    = WAY_W'(1);
            if (look_hit) begin
               way_in     = look_way;
               hit_cnt_in = slcl_pkg::sat_inc(hit_cnt_ff);
               state_in   = slcl_pkg::BK_WRITE;
            end else begin
               way_in      = '0;
               miss_cnt_in = slcl_pkg::sat_inc(miss_cnt_ff);
               state_in    = (WAYS > 1) ? slcl_pkg::BK_SCAN : slcl_pkg::BK_WRITE;
            end
         end
         slcl_pkg::BK_SCAN: begin
            // One way per cycle; strict compare keeps the lowest way on ties.
            if (stamps_ff[idx_ff] < min_ff) begin
               min_in = stamps_ff[idx_ff];
               way_in = idx_ff;
            end
            idx_in = idx_ff + WAY_W'(1);
            if (idx_ff == WAY_W'(WAYS - 1)) begin
               state_in = slcl_pkg::BK_WRITE;
            end
         end
         slcl_pkg::BK_WRITE: begin
            wr_en     = 1'b1;
            strobe_in = 1'b1;
            state_in  = slcl_pkg::BK_IDLE;
         end
         default: state_in = slcl_pkg::BK_IDLE;
      endcase
   end

   assign rsp_strobe = strobe_ff;

endmodule

// File: design/set_associative_lru_cache_lookup_unit.sv
// Top level of the set-associative LRU cache lookup: front end, queue and back end.
// Depends on slcl_pkg, slcl_front, slcl_queue and slcl_back.
//
//   channel   ports                                  direction  beat taken when
//   request   start, busy, req_address               in         start && !busy
//   response  rsp_strobe, rsp_hit, rsp_way_used,     out        every cycle rsp_strobe is high
//             rsp_hit_total, rsp_miss_total
//
// Flow: the back end steps through row read, lookup, one cycle per way in the LRU scan
// on a miss, and row write; that loop sets the rate.
// With a non-power-of-two SETS the front end also passes each accepted address through a
// reciprocal-multiply divide state and a push state before it takes the next address,
// overlapped with the back end through the queue.
// Reset: synchronous; afterwards a clearing sweep invalidates every row, with busy held
// high until it ends.
// Stalls: busy is high during the sweep, when the queue is full, or while the divider
// works on an address; the receiver cannot stall, each result beat lasts one cycle.

module set_associative_lru_cache_lookup_unit #(
   parameter int WAYS        = slcl_pkg::DEF_WAYS,
   parameter int SETS        = slcl_pkg::DEF_SETS,
   parameter int OFFSET_BITS = slcl_pkg::DEF_OFFSET_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [slcl_pkg::ADDR_W-1:0]  req_address,
   output logic                         rsp_strobe,
   output logic                         rsp_hit,
   output logic                         rsp_way_used,
   output logic [slcl_pkg::COUNT_W-1:0] rsp_hit_total,
   output logic [slcl_pkg::COUNT_W-1:0] rsp_miss_total
);

   // Widths follow from the geometry: the tag is whatever is left of the block number.
   localparam int     BLOCK_W   = slcl_pkg::ADDR_W - OFFSET_BITS;
   localparam longint MAX_BLOCK = (longint'(1) << BLOCK_W) - 1;
   localparam int     TAG_BITS  = $clog2(MAX_BLOCK / SETS + 1);
   localparam int     TAG_W     = (TAG_BITS > 0) ? TAG_BITS : 1;
   localparam int     SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int     WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic             accept;
   logic             front_ready;
   logic             clearing;
   logic             push;
   logic [SET_W-1:0] push_set;
   logic [TAG_W-1:0] push_tag;
   logic             pop;
   logic             q_full;
   logic             q_empty;
   logic [SET_W-1:0] q_set;
   logic [TAG_W-1:0] q_tag;

   // Take no request while the sweep runs or the front end cannot take one.
   assign busy   = clearing || !front_ready;
   assign accept = start && !busy;

   slcl_front #(
      .SETS        (SETS),
      .OFFSET_BITS (OFFSET_BITS),
      .SET_W       (SET_W),
      .TAG_W       (TAG_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .address  (req_address),
      .q_full   (q_full),
      .push     (push),
      .push_set (push_set),
      .push_tag (push_tag),
      .ready    (front_ready)
   );

   slcl_queue #(
      .DATA_W (SET_W + TAG_W),
      .DEPTH  (slcl_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_set, push_tag}),
      .pop       (pop),
      .head_data ({q_set, q_tag}),
      .full      (q_full),
      .empty     (q_empty)
   );

   slcl_back #(
      .WAYS  (WAYS),
      .SETS  (SETS),
      .SET_W (SET_W),
      .TAG_W (TAG_W),
      .WAY_W (WAY_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_set          (q_set),
      .q_tag          (q_tag),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total)
   );

endmodule

// File: design/slcl_checker.sv
// Port-level checks for the set-associative LRU cache lookup, bound to the top level.
// Depends on slcl_pkg for the total width.

module slcl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         busy,
   input logic                         rsp_strobe,
   input logic                         rsp_hit,
   input logic [slcl_pkg::COUNT_W-1:0] rsp_hit_total,
   input logic [slcl_pkg::COUNT_W-1:0] rsp_miss_total
);

   // The clearing sweep holds off requests right after reset.
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // A lookup runs from row read through lookup to row write, so result beats never come back to back.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two result beats in consecutive cycles");

   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_hit |-> rsp_hit_total != '0)
      else $error("hit reported with zero hit total");

   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_hit |-> rsp_miss_total != '0)
      else $error("miss reported with zero miss total");

endmodule

bind set_associative_lru_cache_lookup_unit slcl_checker u_slcl_checker (
   .clock          (clock),
   .reset          (reset),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_hit        (rsp_hit),
   .rsp_hit_total  (rsp_hit_total),
   .rsp_miss_total (rsp_miss_total)
);

// File: sim/tb_top.sv
// Self-checking testbench for set_associative_lru_cache_lookup_unit.
// Needs slcl_pkg and the lookup unit; a scoreboard class predicts each lookup beat.
`timescale 1ns / 100ps

module tb_top;

   import slcl_pkg::*;

   // Geometry of the instance: the block's defaults.
   localparam int WAYS        = DEF_WAYS;
   localparam int SETS        = DEF_SETS;
   localparam int OFFSET_BITS = DEF_OFFSET_BITS;
   localparam int SET_BITS    = $clog2(SETS);
   localparam int TAG_W       = ADDR_W - OFFSET_BITS - SET_BITS;

   localparam int RANDOM_ITEMS  = 550;
   localparam int STALL_LIMIT   = 20000;  // covers the clearing sweep after reset
   localparam int DRAIN_CYCLES  = 32;
   localparam int MAX_REPORTS   = 10;
   localparam int HOT_SETS      = 8;
   localparam int HOT_TAGS      = 4;

   typedef struct packed {
      logic               hit;
      logic               way_used;
      logic [COUNT_W-1:0] hit_total;
      logic [COUNT_W-1:0] miss_total;
   } lookup_result_type;

   // Scoreboard: holds its own copy of the tag array and predicts each lookup.
   class cache_scoreboard;
      logic [TAG_W-1:0]   line_tag   [SETS][WAYS];
      bit                 line_valid [SETS][WAYS];
      logic [STAMP_W-1:0] line_stamp [SETS][WAYS];
      logic [STAMP_W-1:0] access_clock;
      logic [COUNT_W-1:0] hit_count;
      logic [COUNT_W-1:0] miss_count;
      lookup_result_type  pending_lookups[$];
      int                 mismatch_count;
      int                 checked_count;
      int                 predicted_hits;
      int                 predicted_misses;

      function new();
         foreach (line_valid[s, w]) begin
            line_tag[s][w]   = '0;
            line_valid[s][w] = 1'b0;
            line_stamp[s][w] = '0;
         end
         access_clock     = '0;
         hit_count        = '0;
         miss_count       = '0;
         mismatch_count   = 0;
         checked_count    = 0;
         predicted_hits   = 0;
         predicted_misses = 0;
      endfunction

      function automatic logic [31:0] step_saturating(input logic [31:0] v);
         return (v == '1) ? v : v + 32'd1;
      endfunction

      // Note one accepted address beat: update the model and queue the expected response.
      function void note_address(input logic [ADDR_W-1:0] addr);
         logic [ADDR_W-OFFSET_BITS-1:0] block_num;
         int                            set_idx;
         logic [TAG_W-1:0]              tag;
         int                            way;
         bit                            found;
         lookup_result_type             res;
         block_num    = addr[ADDR_W-1:OFFSET_BITS];
         set_idx      = int'(block_num[SET_BITS-1:0]);
         tag          = block_num[ADDR_W-OFFSET_BITS-1:SET_BITS];
         found        = 1'b0;
         way          = 0;
         access_clock = step_saturating(access_clock);
         for (int w = 0; w < WAYS; w++) begin
            if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
               found = 1'b1;
               way   = w;
            end
         end
         if (found) begin
            hit_count = step_saturating(hit_count);
            predicted_hits++;
         end else begin
            // Oldest stamp wins, lowest way on ties; empty ways keep stamp zero.
            for (int w = 1; w < WAYS; w++) begin
               if (line_stamp[set_idx][w] < line_stamp[set_idx][way]) way = w;
            end
            line_tag[set_idx][way]   = tag;
            line_valid[set_idx][way] = 1'b1;
            miss_count = step_saturating(miss_count);
            predicted_misses++;
         end
         line_stamp[set_idx][way] = access_clock;
         res.hit        = found;
         res.way_used   = way[0];
         res.hit_total  = hit_count;
         res.miss_total = miss_count;
         pending_lookups = {pending_lookups, res};
      endfunction

      // Check one response beat against the oldest expectation.
      function void check_result(input lookup_result_type got);
         lookup_result_type want;
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch: response beat with no lookup pending (hit=%0b way=%0b)",
                        got.hit, got.way_used);
            return;
         end
         want = pending_lookups.pop_front();
         checked_count++;
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("mismatch on lookup %0d (exp/act): hit %0b/%0b way %0b/%0b",
                        checked_count, want.hit, got.hit, want.way_used, got.way_used);
               $display("   hits %0d/%0d misses %0d/%0d",
                        want.hit_total, got.hit_total, want.miss_total, got.miss_total);
            end
         end
      endfunction

      function int pending();
         return pending_lookups.size();
      endfunction
   endclass

   logic                clock;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic                busy;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic                rsp_way_used;
   logic [COUNT_W-1:0]  rsp_hit_total;
   logic [COUNT_W-1:0]  rsp_miss_total;

   cache_scoreboard     sb = new();
   int                  stall_cycles = 0;
   bit                  idle_allowed = 1'b1;
   logic [SET_BITS-1:0] hot_set [HOT_SETS];
   logic [TAG_W-1:0]    hot_tag [HOT_TAGS];

   set_associative_lru_cache_lookup_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_address    (req_address),
      .rsp_strobe     (rsp_strobe),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Build an address from its tag, set and offset fields.
   function automatic logic [ADDR_W-1:0] make_address(input logic [TAG_W-1:0] tag,
                                                      input logic [SET_BITS-1:0] set_idx,
                                                      input logic [OFFSET_BITS-1:0] offset);
      return {tag, set_idx, offset};
   endfunction

   // Drive one address beat; hold start until the block takes it. Insert a random
   // idle gap first when idling is allowed.
   task automatic send_lookup(input logic [ADDR_W-1:0] addr);
      int gap;
      if (idle_allowed && $urandom_range(0, 99) < 9) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_address <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_address(addr);
   endtask

   // Hold off the sender until every pending lookup has answered.
   task automatic drain_lookups();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Response monitor and stall watchdog: values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_result('{rsp_hit, rsp_way_used, rsp_hit_total, rsp_miss_total});
      if ((start && !busy && !reset) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d lookups pending",
                  stall_cycles, sb.pending());
         $display("[set_associative_lru_cache_lookup_unit] ERROR");
         $finish;
      end
   end

   initial begin
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, empty-way fill order, hits, LRU eviction.
      send_lookup('0);                                           // cold miss, way 0
      send_lookup({ADDR_W{1'b1}});                               // top of address range
      send_lookup(make_address('0, '0, '1));                     // hit, other offset
      send_lookup(make_address(TAG_W'(1), '0, '0));              // empty way 1 fills next
      send_lookup(make_address('0, '0, OFFSET_BITS'(12'h5A5)));  // refresh way 0
      send_lookup(make_address(TAG_W'(2), '0, '0));              // evict way 1 (oldest)
      send_lookup(make_address(TAG_W'(1), '0, '0));              // evict way 0
      send_lookup(make_address(TAG_W'(2), '0, '1));              // hit way 1
      send_lookup(make_address(TAG_W'(1), '0, '0));              // hit way 0
      send_lookup(make_address('1, '1, '0));                     // hit in top set
      send_lookup(make_address('0, '1, '1));                     // second way of top set
      send_lookup(make_address(TAG_W'(8'hAA), SET_BITS'(11'h555), OFFSET_BITS'(12'hAAA)));
      send_lookup(make_address(TAG_W'(8'h55), SET_BITS'(11'h2AA), OFFSET_BITS'(12'h555)));
      send_lookup(make_address(TAG_W'(8'h55), SET_BITS'(11'h555), OFFSET_BITS'(12'h000)));
      send_lookup(make_address(TAG_W'(8'hAA), SET_BITS'(11'h555), OFFSET_BITS'(12'hFFF)));
      send_lookup(make_address(TAG_W'(8'h0F), SET_BITS'(11'h555), OFFSET_BITS'(12'h123)));
      send_lookup(make_address(TAG_W'(8'h55), SET_BITS'(11'h555), OFFSET_BITS'(12'h321)));

      // Random: mostly a small hot working set so sets fill, hit and evict;
      // the rest are addresses drawn from the whole range.
      foreach (hot_set[i]) hot_set[i] = SET_BITS'($urandom);
      foreach (hot_tag[i]) hot_tag[i] = TAG_W'($urandom);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         idle_allowed = !(i >= 100 && i < 260);  // long stretch at full rate
         if (i == 300) drain_lookups();
         pick = $urandom_range(0, 99);
         if (pick < 75)
            send_lookup(make_address(hot_tag[$urandom_range(0, HOT_TAGS - 1)],
                                     hot_set[$urandom_range(0, HOT_SETS - 1)],
                                     OFFSET_BITS'($urandom)));
         else
            send_lookup(ADDR_W'($urandom));
      end

      drain_lookups();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d lookups: %0d hits, %0d misses predicted, %0d responses checked",
               sb.predicted_hits + sb.predicted_misses, sb.predicted_hits,
               sb.predicted_misses, sb.checked_count);
      $display("mismatches: %0d, lookups left pending: %0d", sb.mismatch_count, sb.pending());
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("[set_associative_lru_cache_lookup_unit] OK");
      else
         $display("[set_associative_lru_cache_lookup_unit] ERROR");
      $finish;
   end

endmodule

// File: files.f
design/slcl_pkg.sv
design/slcl_front.sv
design/slcl_queue.sv
design/slcl_back.sv
design/set_associative_lru_cache_lookup_unit.sv
design/slcl_checker.sv
sim/tb_top.sv
